// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file of the sequencer.
// Depends on nothing; guarded against double inclusion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define CHK_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("sdspi assertion failed");
// Asserts that the condition is never seen at a clock edge outside reset.
`define CHK_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("sdspi forbidden condition seen");
`endif

// ===== rtl/sdspi_pkg.sv =====
// Types, codes and constants of the SD SPI-mode command sequencer.
// Used by every design module of the block; depends on nothing.
package sdspi_pkg;

  localparam int unsigned BLK_LEN   = 512;
  localparam int unsigned BLK_SHIFT = $clog2(BLK_LEN);

  // Item kinds
  localparam logic [1:0] FN_REQ  = 2'd0;
  localparam logic [1:0] FN_RX   = 2'd1;
  localparam logic [1:0] FN_TICK = 2'd2;

  // Host request codes
  localparam logic [2:0] REQ_INIT  = 3'd0;
  localparam logic [2:0] REQ_RD    = 3'd1;
  localparam logic [2:0] REQ_RDEND = 3'd2;
  localparam logic [2:0] REQ_WR    = 3'd3;
  localparam logic [2:0] REQ_WREND = 3'd4;
  localparam logic [2:0] REQ_BYTE  = 3'd5;

  // Card kinds
  localparam logic [2:0] CK_NONE = 3'd0;
  localparam logic [2:0] CK_MMC  = 3'd1;
  localparam logic [2:0] CK_SDV1 = 3'd2;
  localparam logic [2:0] CK_SDV2 = 3'd3;
  localparam logic [2:0] CK_SDHC = 3'd4;

  // Command indexes
  localparam logic [5:0] CMD_GO_IDLE  = 6'd0;
  localparam logic [5:0] CMD_SEND_OP  = 6'd1;
  localparam logic [5:0] CMD_IF_COND  = 6'd8;
  localparam logic [5:0] CMD_BLOCKLEN = 6'd16;
  localparam logic [5:0] CMD_RD       = 6'd17;
  localparam logic [5:0] CMD_WR       = 6'd24;
  localparam logic [5:0] CMD_APP_OP   = 6'd41;
  localparam logic [5:0] CMD_READ_OCR = 6'd58;

  localparam logic [31:0] ARG_IF_COND = 32'h0000_01aa;
  localparam logic [31:0] ARG_HCS     = 32'h4000_0000;
  localparam logic [47:0] FRAME_CMD55 = 48'h77_00_00_00_00_65;
  localparam logic [7:0]  CRC_POLY    = 8'h09;
  localparam logic [7:0]  BYTE_IDLE   = 8'hff;
  localparam logic [7:0]  TOK_START   = 8'hfe;
  localparam logic [4:0]  DRESP_OK    = 5'h05;

  // Configuration register indexes
  localparam logic [2:0] REG_SEL_POLL  = 3'd0;
  localparam logic [2:0] REG_INIT_POLL = 3'd1;
  localparam logic [2:0] REG_TOK_POLL  = 3'd2;
  localparam logic [2:0] REG_RESP_POLL = 3'd3;
  localparam logic [2:0] REG_SETTLE    = 3'd4;
  localparam logic [2:0] REG_SEL_TICKS = 3'd5;

  typedef enum logic [4:0] {
    PH_IDLE, PH_DUMMY, PH_SEL_POLL, PH_SEL_WAIT, PH_CMD_LEAD, PH_APP_LEAD,
    PH_CMD_FRAME, PH_CMD_RESP, PH_SETTLE, PH_IFC_DATA, PH_OCR_DATA, PH_TOKEN,
    PH_WR_GAP, PH_WR_TOK, PH_DATA, PH_XFER, PH_RD_END, PH_WR_END, PH_RELEASE
  } phase_t;

  typedef enum logic [3:0] {
    TG_GO_IDLE, TG_IF_COND, TG_HCS, TG_OCR, TG_V1_FIRST, TG_V1_LOOP,
    TG_MMC_LOOP, TG_BLOCKLEN, TG_RD, TG_WR
  } tag_t;

  typedef struct packed {
    logic [15:0] sel_poll;
    logic [15:0] init_poll;
    logic [15:0] tok_poll;
    logic [7:0]  resp_poll;
    logic [9:0]  settle;
    logic [7:0]  sel_ticks;
  } cfg_t;

  typedef struct packed {
    logic        start;
    logic [5:0]  idx;
    logic [31:0] arg;
  } crc_req_t;

  function automatic logic [15:0] lim16(input logic [15:0] x);
    return (x == 16'd0) ? 16'd1 : x;
  endfunction

endpackage

// ===== rtl/sdspi_cfg.sv =====
// APB-style configuration registers of the sequencer.
// Depends on sdspi_pkg for the register indexes and the cfg_t bundle.
module sdspi_cfg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output sdspi_pkg::cfg_t    cfg
);

  sdspi_pkg::cfg_t cfg_r;
  logic [2:0]      idx;
  logic            wr_en;

  assign idx    = paddr[4:2];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  // Write the addressed register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sel_poll  <= 16'd50000;
      cfg_r.init_poll <= 16'd50000;
      cfg_r.tok_poll  <= 16'd50000;
      cfg_r.resp_poll <= 8'd10;
      cfg_r.settle    <= 10'd250;
      cfg_r.sel_ticks <= 8'd1;
    end else if (wr_en) begin
      unique case (idx)
        sdspi_pkg::REG_SEL_POLL:  cfg_r.sel_poll  <= pwdata[15:0];
        sdspi_pkg::REG_INIT_POLL: cfg_r.init_poll <= pwdata[15:0];
        sdspi_pkg::REG_TOK_POLL:  cfg_r.tok_poll  <= pwdata[15:0];
        sdspi_pkg::REG_RESP_POLL: cfg_r.resp_poll <= pwdata[7:0];
        sdspi_pkg::REG_SETTLE:    cfg_r.settle    <= pwdata[9:0];
        sdspi_pkg::REG_SEL_TICKS: cfg_r.sel_ticks <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    unique case (idx)
      sdspi_pkg::REG_SEL_POLL:  prdata = {16'd0, cfg_r.sel_poll};
      sdspi_pkg::REG_INIT_POLL: prdata = {16'd0, cfg_r.init_poll};
      sdspi_pkg::REG_TOK_POLL:  prdata = {16'd0, cfg_r.tok_poll};
      sdspi_pkg::REG_RESP_POLL: prdata = {24'd0, cfg_r.resp_poll};
      sdspi_pkg::REG_SETTLE:    prdata = {22'd0, cfg_r.settle};
      sdspi_pkg::REG_SEL_TICKS: prdata = {24'd0, cfg_r.sel_ticks};
      default:                  prdata = 32'd0;
    endcase
  end

endmodule

// ===== rtl/sdspi_crc7.sv =====
// Bit-serial command frame builder: CRC7 over the five leading bytes.
// One message bit per cycle; depends on sdspi_pkg.
module sdspi_crc7 (
  input  logic                  clk,
  input  logic                  rst_n,
  input  sdspi_pkg::crc_req_t   req,
  output logic                  busy,
  output logic [47:0]           frame
);

  logic [39:0] msg_r, msg_nxt;
  logic [7:0]  crc_r, crc_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [7:0]  sh;

  assign busy  = busy_r;
  assign frame = {msg_r, crc_r[6:0], 1'b1};

  // Load a message on start, else shift one message bit through the CRC and rotate the message back
  always_comb begin
    msg_nxt  = msg_r;
    crc_nxt  = crc_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    sh       = {crc_r[6:0], 1'b0};
    if (req.start) begin
      msg_nxt  = {2'b01, req.idx, req.arg};
      crc_nxt  = 8'd0;
      cnt_nxt  = 6'd40;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      crc_nxt  = (msg_r[39] ^ sh[7]) ? (sh ^ sdspi_pkg::CRC_POLY) : sh;
      msg_nxt  = {msg_r[38:0], msg_r[39]};
      cnt_nxt  = cnt_r - 6'd1;
      busy_nxt = (cnt_r != 6'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= 6'd0;
      msg_r  <= 40'd0;
      crc_r  <= 8'd0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
      msg_r  <= msg_nxt;
      crc_r  <= crc_nxt;
    end
  end

endmodule

// ===== rtl/sdspi_seq.sv =====
// Byte-level sequencer: init ladder, sector begin/end and data exchange.
// Depends on sdspi_pkg; drives the frame builder through a crc_req_t.
module sdspi_seq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sdspi_pkg::cfg_t      cfg,
  input  logic                 step,
  input  logic [1:0]           func,
  input  logic [2:0]           request,
  input  logic [31:0]          sector,
  input  logic [7:0]           data_out,
  input  logic [7:0]           rx_byte,
  input  logic [47:0]          frame,
  output sdspi_pkg::crc_req_t  crc_req,
  input  logic                 res_take,
  output logic                 res_valid,
  output logic                 tx_valid,
  output logic [7:0]           tx_byte,
  output logic                 chip_select,
  output logic                 fast_clock,
  output logic                 done_res,
  output logic                 success,
  output logic [2:0]           card_kind,
  output logic [7:0]           rx_data
);

  sdspi_pkg::phase_t phase_r, phase_nxt;
  sdspi_pkg::tag_t   tag_r, tag_nxt;
  logic [2:0]  card_r, card_nxt, found_r, found_nxt, act_r, act_nxt;
  logic        speed_r, speed_nxt, cs_r, cs_nxt, app_r, app_nxt, fok_r, fok_nxt;
  logic [2:0]  fi_r, fi_nxt;
  logic [15:0] retry_r, retry_nxt;
  logic [9:0]  tick_r, tick_nxt;
  logic [31:0] ocr_r, ocr_nxt, blk_r, blk_nxt;
  logic [7:0]  resp_r, resp_nxt;

  logic        vld_r, txv_r, done_r, ok_r;
  logic [7:0]  txb_r, rxd_r;

  logic       txv_r_nxt, done_r_nxt, ok_r_nxt;
  logic [7:0] txb_r_nxt, rxd_r_nxt;

  function automatic logic [7:0] pick(input logic [47:0] fr, input logic [2:0] i);
    logic [47:0] s;
    s = fr >> (6'd8 * (6'd5 - {3'd0, i}));
    return s[7:0];
  endfunction

  always_comb begin
    logic        txv, done, ok, do_cmd, do_tail, do_rel, do_sel, do_frm, st;
    logic [7:0]  txb, rxo, r;
    logic [47:0] fr;
    logic [5:0]  s_idx;
    logic [31:0] s_arg;
    logic        s_app;
    sdspi_pkg::tag_t s_tag;

    phase_nxt = phase_r; tag_nxt = tag_r; card_nxt = card_r; found_nxt = found_r;
    act_nxt = act_r; speed_nxt = speed_r; cs_nxt = cs_r; app_nxt = app_r;
    fok_nxt = fok_r; fi_nxt = fi_r; retry_nxt = retry_r; tick_nxt = tick_r;
    ocr_nxt = ocr_r; blk_nxt = blk_r; resp_nxt = resp_r;
    txv = 1'b0; txb = 8'd0; done = 1'b0; ok = 1'b0; rxo = 8'd0;
    do_cmd = 1'b0; do_tail = 1'b0; do_rel = 1'b0; do_sel = 1'b0; do_frm = 1'b0;
    st = 1'b0; r = rx_byte; s_idx = 6'd0; s_arg = 32'd0; s_app = 1'b0;
    s_tag = tag_r; fr = 48'd0;

    // Dispatch the item on its kind
    unique case (func)
      sdspi_pkg::FN_REQ: begin
        if (phase_r == sdspi_pkg::PH_IDLE) begin
          if (request == sdspi_pkg::REQ_INIT) begin
            act_nxt = sdspi_pkg::REQ_INIT; found_nxt = sdspi_pkg::CK_NONE;
            cs_nxt = 1'b0; speed_nxt = 1'b0; retry_nxt = 16'd10;
            txv = 1'b1; txb = sdspi_pkg::BYTE_IDLE; phase_nxt = sdspi_pkg::PH_DUMMY;
          end else if ((request == sdspi_pkg::REQ_RD || request == sdspi_pkg::REQ_WR) &&
                       card_r != sdspi_pkg::CK_NONE) begin
            act_nxt = request;
            blk_nxt = (card_r == sdspi_pkg::CK_SDHC) ? sector
                                                      : (sector << sdspi_pkg::BLK_SHIFT);
            do_sel = 1'b1;
          end else begin
            done = 1'b1;
          end
        end else if (phase_r == sdspi_pkg::PH_DATA) begin
          if (request == sdspi_pkg::REQ_BYTE) begin
            txv = 1'b1; txb = data_out; phase_nxt = sdspi_pkg::PH_XFER;
          end else if (request == sdspi_pkg::REQ_RDEND && act_r == sdspi_pkg::REQ_RD) begin
            fi_nxt = 3'd0; txv = 1'b1; txb = sdspi_pkg::BYTE_IDLE;
            phase_nxt = sdspi_pkg::PH_RD_END;
          end else if (request == sdspi_pkg::REQ_WREND && act_r == sdspi_pkg::REQ_WR) begin
            fi_nxt = 3'd0; txv = 1'b1; txb = sdspi_pkg::BYTE_IDLE;
            phase_nxt = sdspi_pkg::PH_WR_END;
          end else begin
            done = 1'b1;
          end
        end
      end
      sdspi_pkg::FN_RX: begin
        unique case (phase_r) inside
          sdspi_pkg::PH_DUMMY: begin
            retry_nxt = retry_r - 16'd1;
            if (retry_nxt != 16'd0) begin
              txv = 1'b1; txb = sdspi_pkg::BYTE_IDLE;
            end else do_sel = 1'b1;
          end
          sdspi_pkg::PH_SEL_POLL: begin
            if (rx_byte == sdspi_pkg::BYTE_IDLE) begin
              st = 1'b1;
              if (act_r == sdspi_pkg::REQ_INIT) begin
                s_idx = sdspi_pkg::CMD_GO_IDLE; s_tag = sdspi_pkg::TG_GO_IDLE;
              end else if (act_r == sdspi_pkg::REQ_RD) begin
                s_idx = sdspi_pkg::CMD_RD; s_arg = blk_r; s_tag = sdspi_pkg::TG_RD;
              end else begin
                s_idx = sdspi_pkg::CMD_WR; s_arg = blk_r; s_tag = sdspi_pkg::TG_WR;
              end
            end else begin
              retry_nxt = retry_r - 16'd1;
              tick_nxt = {2'd0, cfg.sel_ticks};
              if (cfg.sel_ticks == 8'd0) begin
                if (retry_nxt == 16'd0) begin
                  fok_nxt = 1'b0; found_nxt = sdspi_pkg::CK_NONE; do_rel = 1'b1;
                end else begin
                  txv = 1'b1; txb = sdspi_pkg::BYTE_IDLE;
                end
              end else phase_nxt = sdspi_pkg::PH_SEL_WAIT;
            end
          end
          sdspi_pkg::PH_CMD_LEAD: begin
            if (app_r) begin
              txv = 1'b1; txb = sdspi_pkg::BYTE_IDLE; phase_nxt = sdspi_pkg::PH_APP_LEAD;
            end else do_frm = 1'b1;
          end
          sdspi_pkg::PH_APP_LEAD: do_frm = 1'b1;
          sdspi_pkg::PH_CMD_FRAME: begin
            fi_nxt = fi_r + 3'd1;
            txv = 1'b1;
            if (fi_nxt < 3'd6) begin
              fr = app_r ? sdspi_pkg::FRAME_CMD55 : frame;
              txb = pick(fr, fi_nxt);
            end else begin
              resp_nxt = (cfg.resp_poll == 8'd0) ? 8'd1 : cfg.resp_poll;
              txb = sdspi_pkg::BYTE_IDLE; phase_nxt = sdspi_pkg::PH_CMD_RESP;
            end
          end
          sdspi_pkg::PH_CMD_RESP: begin
            if (rx_byte == sdspi_pkg::BYTE_IDLE && resp_r > 8'd1) begin
              resp_nxt = resp_r - 8'd1; txv = 1'b1; txb = sdspi_pkg::BYTE_IDLE;
            end else if (app_r) begin
              app_nxt = 1'b0;
              if (rx_byte > 8'd1) do_cmd = 1'b1; else do_frm = 1'b1;
            end else do_cmd = 1'b1;
          end
          sdspi_pkg::PH_IFC_DATA, sdspi_pkg::PH_OCR_DATA: begin
            ocr_nxt = {ocr_r[23:0], rx_byte};
            fi_nxt = fi_r + 3'd1;
            if (fi_nxt < 3'd4) begin
              txv = 1'b1; txb = sdspi_pkg::BYTE_IDLE;
            end else if (phase_r == sdspi_pkg::PH_OCR_DATA) begin
              found_nxt = ocr_nxt[30] ? sdspi_pkg::CK_SDHC : sdspi_pkg::CK_SDV2;
              do_tail = 1'b1;
            end else if (ocr_nxt[15:0] == sdspi_pkg::ARG_IF_COND[15:0]) begin
              retry_nxt = sdspi_pkg::lim16(cfg.init_poll);
              st = 1'b1; s_idx = sdspi_pkg::CMD_APP_OP; s_app = 1'b1;
              s_arg = sdspi_pkg::ARG_HCS; s_tag = sdspi_pkg::TG_HCS;
            end else do_tail = 1'b1;
          end
          sdspi_pkg::PH_TOKEN: begin
            if (rx_byte == sdspi_pkg::BYTE_IDLE && retry_r > 16'd1) begin
              retry_nxt = retry_r - 16'd1; txv = 1'b1; txb = sdspi_pkg::BYTE_IDLE;
            end else if (rx_byte == sdspi_pkg::TOK_START) begin
              phase_nxt = sdspi_pkg::PH_DATA; done = 1'b1; ok = 1'b1;
            end else begin
              fok_nxt = 1'b0; do_rel = 1'b1;
            end
          end
          sdspi_pkg::PH_WR_GAP: begin
            txv = 1'b1; txb = sdspi_pkg::TOK_START; phase_nxt = sdspi_pkg::PH_WR_TOK;
          end
          sdspi_pkg::PH_WR_TOK: begin
            phase_nxt = sdspi_pkg::PH_DATA; done = 1'b1; ok = 1'b1;
          end
          sdspi_pkg::PH_XFER: begin
            phase_nxt = sdspi_pkg::PH_DATA; rxo = rx_byte; done = 1'b1; ok = 1'b1;
          end
          sdspi_pkg::PH_RD_END: begin
            fi_nxt = fi_r + 3'd1;
            if (fi_nxt < 3'd2) begin
              txv = 1'b1; txb = sdspi_pkg::BYTE_IDLE;
            end else begin
              fok_nxt = 1'b1; do_rel = 1'b1;
            end
          end
          sdspi_pkg::PH_WR_END: begin
            fi_nxt = fi_r + 3'd1;
            if (fi_nxt < 3'd3) begin
              txv = 1'b1; txb = sdspi_pkg::BYTE_IDLE;
            end else begin
              fok_nxt = (rx_byte[4:0] == sdspi_pkg::DRESP_OK); do_rel = 1'b1;
            end
          end
          sdspi_pkg::PH_RELEASE: begin
            phase_nxt = sdspi_pkg::PH_IDLE; done = 1'b1;
            if (act_r == sdspi_pkg::REQ_INIT) begin
              card_nxt = found_r; ok = (found_r != sdspi_pkg::CK_NONE);
            end else ok = fok_r;
          end
          default: ;
        endcase
      end
      sdspi_pkg::FN_TICK: begin
        if (phase_r == sdspi_pkg::PH_SETTLE || phase_r == sdspi_pkg::PH_SEL_WAIT) begin
          tick_nxt = (tick_r != 10'd0) ? tick_r - 10'd1 : 10'd0;
          if (tick_nxt == 10'd0) begin
            if (phase_r == sdspi_pkg::PH_SETTLE) begin
              speed_nxt = 1'b1; st = 1'b1; s_idx = sdspi_pkg::CMD_IF_COND;
              s_arg = sdspi_pkg::ARG_IF_COND; s_tag = sdspi_pkg::TG_IF_COND;
            end else if (retry_r == 16'd0) begin
              fok_nxt = 1'b0; found_nxt = sdspi_pkg::CK_NONE; do_rel = 1'b1;
            end else begin
              txv = 1'b1; txb = sdspi_pkg::BYTE_IDLE; phase_nxt = sdspi_pkg::PH_SEL_POLL;
            end
          end
        end
      end
      default: ;
    endcase

    // Act on the command response
    if (do_cmd) begin
      unique case (tag_r) inside
        sdspi_pkg::TG_GO_IDLE: begin
          if (r <= 8'd1) begin
            tick_nxt = cfg.settle;
            if (cfg.settle == 10'd0) begin
              speed_nxt = 1'b1; st = 1'b1; s_idx = sdspi_pkg::CMD_IF_COND;
              s_arg = sdspi_pkg::ARG_IF_COND; s_tag = sdspi_pkg::TG_IF_COND;
            end else phase_nxt = sdspi_pkg::PH_SETTLE;
          end else do_tail = 1'b1;
        end
        sdspi_pkg::TG_IF_COND: begin
          if (r <= 8'd1) begin
            fi_nxt = 3'd0; ocr_nxt = 32'd0; txv = 1'b1; txb = sdspi_pkg::BYTE_IDLE;
            phase_nxt = sdspi_pkg::PH_IFC_DATA;
          end else begin
            st = 1'b1; s_idx = sdspi_pkg::CMD_APP_OP; s_app = 1'b1;
            s_tag = sdspi_pkg::TG_V1_FIRST;
          end
        end
        sdspi_pkg::TG_OCR: begin
          if (r == 8'd0) begin
            fi_nxt = 3'd0; ocr_nxt = 32'd0; txv = 1'b1; txb = sdspi_pkg::BYTE_IDLE;
            phase_nxt = sdspi_pkg::PH_OCR_DATA;
          end else do_tail = 1'b1;
        end
        sdspi_pkg::TG_V1_FIRST: begin
          retry_nxt = sdspi_pkg::lim16(cfg.init_poll);
          st = 1'b1;
          if (r <= 8'd1) begin
            s_idx = sdspi_pkg::CMD_APP_OP; s_app = 1'b1; s_tag = sdspi_pkg::TG_V1_LOOP;
          end else begin
            s_idx = sdspi_pkg::CMD_SEND_OP; s_tag = sdspi_pkg::TG_MMC_LOOP;
          end
        end
        sdspi_pkg::TG_HCS, sdspi_pkg::TG_V1_LOOP, sdspi_pkg::TG_MMC_LOOP: begin
          if (r == 8'd0) begin
            if (tag_r == sdspi_pkg::TG_HCS) begin
              st = 1'b1; s_idx = sdspi_pkg::CMD_READ_OCR; s_tag = sdspi_pkg::TG_OCR;
            end else begin
              found_nxt = (tag_r == sdspi_pkg::TG_V1_LOOP) ? sdspi_pkg::CK_SDV1
                                                           : sdspi_pkg::CK_MMC;
              do_tail = 1'b1;
            end
          end else begin
            retry_nxt = retry_r - 16'd1;
            if (retry_nxt == 16'd0) do_tail = 1'b1;
            else begin
              st = 1'b1; s_tag = tag_r;
              if (tag_r == sdspi_pkg::TG_MMC_LOOP) s_idx = sdspi_pkg::CMD_SEND_OP;
              else begin
                s_idx = sdspi_pkg::CMD_APP_OP; s_app = 1'b1;
                s_arg = (tag_r == sdspi_pkg::TG_HCS) ? sdspi_pkg::ARG_HCS : 32'd0;
              end
            end
          end
        end
        sdspi_pkg::TG_BLOCKLEN: do_rel = 1'b1;
        sdspi_pkg::TG_RD: begin
          if (r == 8'd0) begin
            retry_nxt = sdspi_pkg::lim16(cfg.tok_poll);
            txv = 1'b1; txb = sdspi_pkg::BYTE_IDLE; phase_nxt = sdspi_pkg::PH_TOKEN;
          end else begin
            fok_nxt = 1'b0; do_rel = 1'b1;
          end
        end
        default: begin
          if (r == 8'd0) begin
            txv = 1'b1; txb = sdspi_pkg::BYTE_IDLE; phase_nxt = sdspi_pkg::PH_WR_GAP;
          end else begin
            fok_nxt = 1'b0; do_rel = 1'b1;
          end
        end
      endcase
    end

    // Finish init: set the block length for MMC and SD v1/v2 cards, else drop select
    if (do_tail) begin
      if (found_nxt >= sdspi_pkg::CK_MMC && found_nxt <= sdspi_pkg::CK_SDV2) begin
        st = 1'b1; s_idx = sdspi_pkg::CMD_BLOCKLEN; s_app = 1'b0;
        s_arg = 32'(sdspi_pkg::BLK_LEN); s_tag = sdspi_pkg::TG_BLOCKLEN;
      end else do_rel = 1'b1;
    end
    if (do_rel) begin
      cs_nxt = 1'b0; txv = 1'b1; txb = sdspi_pkg::BYTE_IDLE;
      phase_nxt = sdspi_pkg::PH_RELEASE;
    end
    if (do_sel) begin
      cs_nxt = 1'b1; retry_nxt = sdspi_pkg::lim16(cfg.sel_poll);
      txv = 1'b1; txb = sdspi_pkg::BYTE_IDLE; phase_nxt = sdspi_pkg::PH_SEL_POLL;
    end
    if (do_frm) begin
      fi_nxt = 3'd0; txv = 1'b1;
      fr = app_nxt ? sdspi_pkg::FRAME_CMD55 : frame;
      txb = pick(fr, 3'd0); phase_nxt = sdspi_pkg::PH_CMD_FRAME;
    end
    if (st) begin
      app_nxt = s_app; tag_nxt = s_tag; txv = 1'b1; txb = sdspi_pkg::BYTE_IDLE;
      phase_nxt = sdspi_pkg::PH_CMD_LEAD;
    end

    crc_req.start = step & st;
    crc_req.idx   = s_idx;
    crc_req.arg   = s_arg;

    txv_r_nxt  = txv;
    txb_r_nxt  = txb;
    done_r_nxt = done;
    ok_r_nxt   = ok;
    rxd_r_nxt  = rxo;
  end

  // Hold the state; advance it on an accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= sdspi_pkg::PH_IDLE; tag_r <= sdspi_pkg::TG_GO_IDLE;
      card_r <= sdspi_pkg::CK_NONE; found_r <= sdspi_pkg::CK_NONE; act_r <= 3'd0;
      speed_r <= 1'b0; cs_r <= 1'b0; app_r <= 1'b0; fok_r <= 1'b0; fi_r <= 3'd0;
      retry_r <= 16'd0; tick_r <= 10'd0; ocr_r <= 32'd0; blk_r <= 32'd0;
      resp_r <= 8'd0; vld_r <= 1'b0;
    end else begin
      if (step) begin
        phase_r <= phase_nxt; tag_r <= tag_nxt; card_r <= card_nxt;
        found_r <= found_nxt; act_r <= act_nxt; speed_r <= speed_nxt;
        cs_r <= cs_nxt; app_r <= app_nxt; fok_r <= fok_nxt; fi_r <= fi_nxt;
        retry_r <= retry_nxt; tick_r <= tick_nxt; ocr_r <= ocr_nxt;
        blk_r <= blk_nxt; resp_r <= resp_nxt;
      end
      if (step) vld_r <= 1'b1;
      else if (res_take) vld_r <= 1'b0;
    end
  end

  // Capture the result item
  always_ff @(posedge clk) begin
    if (step) begin
      txv_r  <= txv_r_nxt;
      txb_r  <= txb_r_nxt;
      done_r <= done_r_nxt;
      ok_r   <= ok_r_nxt;
      rxd_r  <= rxd_r_nxt;
    end
  end

  assign res_valid   = vld_r;
  assign tx_valid    = txv_r;
  assign tx_byte     = txb_r;
  assign done_res    = done_r;
  assign success     = ok_r;
  assign rx_data     = rxd_r;
  assign chip_select = cs_r;
  assign fast_clock  = speed_r;
  assign card_kind   = card_r;

endmodule

// ===== rtl/sd_spi_command_sequencer_top.sv =====
// SD SPI-mode command sequencer: one result item per input item.
// The registered result appears in the cycle after the item is taken.
// No item is taken while a result waits or while the bit-serial CRC7
// frame builder is shifting the 40 message bits of a command frame.
// Reset (synchronous, active low): idle, deselected, slow clock, no card.
module sd_spi_command_sequencer_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic [2:0]  in_request,
  input  logic [31:0] in_sector,
  input  logic [7:0]  in_data_out,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_tx_valid,
  output logic [7:0]  out_tx_byte,
  output logic        out_chip_select,
  output logic        out_fast_clock,
  output logic        out_done_res,
  output logic        out_success,
  output logic [2:0]  out_card_kind,
  output logic [7:0]  out_rx_data
);

  sdspi_pkg::cfg_t     cfg;
  sdspi_pkg::crc_req_t crc_req;
  logic                crc_busy;
  logic [47:0]         frame;
  logic                step;

  // Take an item only when the result slot is free and no frame is building
  assign in_stall = out_valid | crc_busy;
  assign step     = in_valid & ~in_stall;

  sdspi_cfg u_cfg (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  sdspi_crc7 u_crc (
    .clk, .rst_n, .req(crc_req), .busy(crc_busy), .frame
  );

  sdspi_seq u_seq (
    .clk, .rst_n, .cfg, .step,
    .func(in_func), .request(in_request), .sector(in_sector),
    .data_out(in_data_out), .rx_byte(in_rx_byte), .frame, .crc_req,
    .res_take(~out_stall), .res_valid(out_valid),
    .tx_valid(out_tx_valid), .tx_byte(out_tx_byte),
    .chip_select(out_chip_select), .fast_clock(out_fast_clock),
    .done_res(out_done_res), .success(out_success),
    .card_kind(out_card_kind), .rx_data(out_rx_data)
  );

endmodule

// ===== rtl/sdspi_chk.sv =====
// Port-level checker for the sequencer, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"
module sdspi_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_tx_valid,
  input logic [7:0] out_tx_byte,
  input logic       out_done_res,
  input logic       out_success
);

  `CHK_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid)
  `CHK_ASSERT(a_item_result, clk, rst_n, in_valid && !in_stall |=> out_valid)
  `CHK_ASSERT(a_one_in_flight, clk, rst_n, out_valid |-> in_stall)
  `CHK_NEVER(a_idle_byte, clk, rst_n, out_valid && !out_tx_valid && out_tx_byte != 8'd0)
  `CHK_NEVER(a_ok_done, clk, rst_n, out_valid && out_success && !out_done_res)

endmodule

bind sd_spi_command_sequencer_top sdspi_chk u_sdspi_chk (.*);
